### rtl/core/pwvc_pkg.sv
`default_nettype none
package pwvc_pkg;

    localparam int VEC_DEPTH = 32;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int VEC_CW    = $clog2(VEC_DEPTH + 1);
    localparam int OWNER_W   = 16;
    localparam int FRAME_W   = 36;
    localparam int PAGE_W    = 32;
    localparam int CNT_W     = 16;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd256;
    localparam logic [CNT_W-1:0] LIMIT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [FRAME_W-1:0] base;
        logic [CNT_W-1:0]   len;
    } vec_entry_t;

    // open transfer bookkeeping
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  first_page;
        logic [CNT_W-1:0]   page_total;
        logic [VEC_CW-1:0]  used;
        logic [VEC_AW-1:0]  head;
    } xfer_state_t;

    // merge decision for one page against the open transfer
    typedef struct packed {
        logic               join_ok;
        logic [VEC_AW-1:0]  wr_addr;
        vec_entry_t         wr_data;
        logic [PAGE_W-1:0]  first_page;
        logic [VEC_AW-1:0]  head;
        logic               add_vec;
    } merge_t;

endpackage
`default_nettype wire

### rtl/core/page_write_vector_coalescer.sv
// Page write vector coalescer.
// s_ channel: one dirty page or a flush per transfer. s_tdata carries
// owner_id, phys_frame and logical_page; s_tuser[0] is flush_only.
// m_ channel: one scatter-gather vector per transfer, emitted when a
// transfer closes; m_tlast marks the final vector of the list.
// cfg_ channel: max_pages_per_transfer (0 selects 65535), always ready;
// write it only while the block is idle.
// Steps: a page that opens a transfer is written straight from idle; a
// page that joins is a vector ram read, then modify and write back. A page
// that closes a transfer is a ram read and evaluation, then per stored
// vector a ram read, output load and output transfer; a flush goes straight
// to the vectors. Each output transfer is stretched by however long
// m_tready stays low. Only one item is in work at a time; s_tready is low
// until its last vector has been taken.
// Reset (aresetn low, synchronous): no transfer open, limit back to 256,
// no output pending. The vector ram needs no clearing: only entries of
// the open transfer are ever read.
`default_nettype none
module page_write_vector_coalescer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] owner_id, [51:16] phys_frame, [83:52] logical_page
    input  wire logic [87:0]  s_tdata,
    // [0] flush_only
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [4:0] vec_index, [40:5] vec_base_frame, [56:41] vec_frames,
    // [72:57] xfer_owner, [104:73] xfer_first_page, [120:105] xfer_page_total
    output logic [127:0]      m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_EVAL      = 5'b00010,
        S_EMIT_RD   = 5'b00100,
        S_EMIT_LD   = 5'b01000,
        S_EMIT_WAIT = 5'b10000
    } state_t;

    state_t                              state_reg, state_next;
    logic [pwvc_pkg::CNT_W-1:0]          limit_cfg_reg;
    logic                                open_reg, open_next;
    pwvc_pkg::xfer_state_t               xs_reg, xs_next;
    logic [pwvc_pkg::VEC_AW-1:0]         idx_reg, idx_next;

    logic [pwvc_pkg::OWNER_W-1:0]        pend_owner_reg;
    logic [pwvc_pkg::FRAME_W-1:0]        pend_frame_reg;
    logic [pwvc_pkg::PAGE_W-1:0]         pend_lp_reg;
    logic                                pend_flush_reg;

    logic                                out_valid_reg, out_valid_next;
    logic [120:0]                        out_data_reg;
    logic                                out_last_reg;
    logic                                out_load;

    logic                                s_xfer;
    logic                                m_xfer;
    logic                                emit_last;
    logic [pwvc_pkg::CNT_W-1:0]          limit;
    logic [pwvc_pkg::VEC_AW-1:0]         last_addr;

    logic                                wr_en;
    logic [pwvc_pkg::VEC_AW-1:0]         wr_addr;
    pwvc_pkg::vec_entry_t                wr_data;
    logic [pwvc_pkg::VEC_AW-1:0]         rd_addr_a;
    pwvc_pkg::vec_entry_t                rd_data_a;
    pwvc_pkg::vec_entry_t                rd_data_b;
    pwvc_pkg::merge_t                    mres;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_xfer    = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, out_data_reg};
    assign m_tlast   = out_last_reg;

    assign limit     = (limit_cfg_reg == '0) ? pwvc_pkg::LIMIT_MAX : limit_cfg_reg;
    assign last_addr = xs_reg.head + xs_reg.used[pwvc_pkg::VEC_AW-1:0] - 1'b1;
    assign emit_last = (({1'b0, idx_reg} + 1'b1) == xs_reg.used);
    assign rd_addr_a = (state_reg == S_EMIT_RD) ? (xs_reg.head + idx_reg) : last_addr;

    pwvc_vec_ram u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (xs_reg.head),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    pwvc_merge u_merge (
        .xs        (xs_reg),
        .limit     (limit),
        .owner     (pend_owner_reg),
        .frame     (pend_frame_reg),
        .lp        (pend_lp_reg),
        .last_addr (last_addr),
        .last_ent  (rd_data_a),
        .front_ent (rd_data_b),
        .res       (mres)
    );

    always_comb begin
        state_next     = state_reg;
        open_next      = open_reg;
        xs_next        = xs_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data.base   = pend_frame_reg;
        wr_data.len    = pwvc_pkg::CNT_W'(1);

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser[0]) begin
                        if (open_reg) begin
                            idx_next   = '0;
                            state_next = S_EMIT_RD;
                        end
                    end else if (!open_reg) begin
                        wr_en              = 1'b1;
                        wr_data.base       = s_tdata[51:16];
                        open_next          = 1'b1;
                        xs_next.owner      = s_tdata[15:0];
                        xs_next.first_page = s_tdata[83:52];
                        xs_next.page_total = pwvc_pkg::CNT_W'(1);
                        xs_next.used       = pwvc_pkg::VEC_CW'(1);
                        xs_next.head       = '0;
                    end else begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (mres.join_ok) begin
                    wr_en              = 1'b1;
                    wr_addr            = mres.wr_addr;
                    wr_data            = mres.wr_data;
                    xs_next.first_page = mres.first_page;
                    xs_next.head       = mres.head;
                    xs_next.page_total = xs_reg.page_total + 1'b1;
                    if (mres.add_vec) begin
                        xs_next.used = xs_reg.used + 1'b1;
                    end
                    state_next = S_IDLE;
                end else begin
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (m_xfer) begin
                    out_valid_next = 1'b0;
                    if (!emit_last) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end else begin
                        state_next = S_IDLE;
                        if (pend_flush_reg) begin
                            open_next          = 1'b0;
                            xs_next.used       = '0;
                            xs_next.page_total = '0;
                        end else begin
                            // closing page opens the next transfer
                            wr_en              = 1'b1;
                            open_next          = 1'b1;
                            xs_next.owner      = pend_owner_reg;
                            xs_next.first_page = pend_lp_reg;
                            xs_next.page_total = pwvc_pkg::CNT_W'(1);
                            xs_next.used       = pwvc_pkg::VEC_CW'(1);
                            xs_next.head       = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            limit_cfg_reg <= pwvc_pkg::LIMIT_RESET;
            open_reg      <= 1'b0;
            xs_reg        <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            xs_reg        <= xs_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                limit_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pend_owner_reg <= s_tdata[15:0];
            pend_frame_reg <= s_tdata[51:16];
            pend_lp_reg    <= s_tdata[83:52];
            pend_flush_reg <= s_tuser[0];
        end
        if (out_load) begin
            out_data_reg <= {xs_reg.page_total, xs_reg.first_page, xs_reg.owner,
                             rd_data_a.len, rd_data_a.base, idx_reg};
            out_last_reg <= emit_last;
        end
    end

endmodule
`default_nettype wire

### rtl/core/pwvc_vec_ram.sv
`default_nettype none
module pwvc_vec_ram (
    input  wire logic                            aclk,
    input  wire logic                            wr_en,
    input  wire logic [pwvc_pkg::VEC_AW-1:0]     wr_addr,
    input  wire pwvc_pkg::vec_entry_t            wr_data,
    input  wire logic [pwvc_pkg::VEC_AW-1:0]     rd_addr_a,
    input  wire logic [pwvc_pkg::VEC_AW-1:0]     rd_addr_b,
    output pwvc_pkg::vec_entry_t                 rd_data_a,
    output pwvc_pkg::vec_entry_t                 rd_data_b
);

    pwvc_pkg::vec_entry_t mem [pwvc_pkg::VEC_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

### rtl/core/pwvc_merge.sv
`default_nettype none
module pwvc_merge (
    input  wire pwvc_pkg::xfer_state_t                xs,
    input  wire logic [pwvc_pkg::CNT_W-1:0]           limit,
    input  wire logic [pwvc_pkg::OWNER_W-1:0]         owner,
    input  wire logic [pwvc_pkg::FRAME_W-1:0]         frame,
    input  wire logic [pwvc_pkg::PAGE_W-1:0]          lp,
    input  wire logic [pwvc_pkg::VEC_AW-1:0]          last_addr,
    input  wire pwvc_pkg::vec_entry_t                 last_ent,
    input  wire pwvc_pkg::vec_entry_t                 front_ent,
    output pwvc_pkg::merge_t                          res
);

    logic                           can_join;
    logic [pwvc_pkg::PAGE_W:0]      after;
    logic [pwvc_pkg::FRAME_W:0]     last_end;
    logic                           lp_after;
    logic                           before_ok;
    logic                           ext_last;
    logic                           ext_front;
    logic                           vec_free;
    logic                           new_vec;

    always_comb begin
        can_join  = (owner == xs.owner) && (xs.page_total < limit);
        after     = {1'b0, xs.first_page} + {{(pwvc_pkg::PAGE_W+1-pwvc_pkg::CNT_W){1'b0}},
                                             xs.page_total};
        lp_after  = ({1'b0, lp} == after);
        before_ok = (xs.first_page != '0) && (lp == xs.first_page - 1'b1);
        last_end  = {1'b0, last_ent.base} +
                    {{(pwvc_pkg::FRAME_W+1-pwvc_pkg::CNT_W){1'b0}}, last_ent.len};
        ext_last  = lp_after && ({1'b0, frame} == last_end);
        ext_front = before_ok && (front_ent.base != '0) &&
                    (frame == front_ent.base - 1'b1);
        vec_free  = (xs.used < pwvc_pkg::VEC_CW'(pwvc_pkg::VEC_DEPTH));
        new_vec   = (lp_after || before_ok) && vec_free;

        res            = '0;
        res.first_page = xs.first_page;
        res.head       = xs.head;
        res.join_ok    = can_join && (ext_last || ext_front || new_vec);
        if (ext_last) begin
            res.wr_addr      = last_addr;
            res.wr_data.base = last_ent.base;
            res.wr_data.len  = last_ent.len + 1'b1;
        end else if (ext_front) begin
            res.wr_addr      = xs.head;
            res.wr_data.base = frame;
            res.wr_data.len  = front_ent.len + 1'b1;
            res.first_page   = lp;
        end else begin
            res.add_vec      = 1'b1;
            res.wr_data.base = frame;
            res.wr_data.len  = pwvc_pkg::CNT_W'(1);
            if (!lp_after) begin
                // new vector in front of the ring
                res.head       = xs.head - 1'b1;
                res.wr_addr    = xs.head - 1'b1;
                res.first_page = lp;
            end else begin
                res.wr_addr    = xs.head + xs.used[pwvc_pkg::VEC_AW-1:0];
            end
        end
    end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS   = 50_000_000;

    typedef struct packed {
        logic [pwvc_pkg::OWNER_W-1:0] owner;
        logic [pwvc_pkg::FRAME_W-1:0] frame;
        logic [pwvc_pkg::PAGE_W-1:0]  lpage;
        logic                         flush;
    } page_item_t;

    typedef struct packed {
        logic [pwvc_pkg::VEC_AW-1:0]  idx;
        logic [pwvc_pkg::FRAME_W-1:0] base;
        logic [pwvc_pkg::CNT_W-1:0]   frames;
        logic [pwvc_pkg::OWNER_W-1:0] owner;
        logic [pwvc_pkg::PAGE_W-1:0]  first;
        logic [pwvc_pkg::CNT_W-1:0]   total;
        logic                         last;
    } sg_vec_t;

    typedef enum {
        PG_FRESH, PG_TAIL_EXT, PG_FRONT_EXT, PG_NEW_TAIL, PG_NEW_FRONT,
        PG_OWNER_SWAP, PG_GAP
    } page_shape_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata   = '0;   // [15:0] owner_id, [51:16] phys_frame, [83:52] logical_page
    logic [0:0]   s_tuser   = '0;   // [0] flush_only
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;          // [4:0] vec_index, [40:5] vec_base_frame,
                                    // [56:41] vec_frames, [72:57] xfer_owner,
                                    // [104:73] xfer_first_page, [120:105] xfer_page_total
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data  = '0;

    page_write_vector_coalescer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // coalescer state as the block should hold it
    logic [pwvc_pkg::CNT_W-1:0]   page_limit;
    bit                           xf_open;
    logic [pwvc_pkg::OWNER_W-1:0] xf_owner;
    logic [pwvc_pkg::PAGE_W-1:0]  xf_first;
    logic [pwvc_pkg::CNT_W-1:0]   xf_total;
    int                           xf_used;
    int                           xf_head;
    logic [pwvc_pkg::FRAME_W-1:0] ring_base [pwvc_pkg::VEC_DEPTH];
    logic [pwvc_pkg::CNT_W-1:0]   ring_len  [pwvc_pkg::VEC_DEPTH];

    sg_vec_t closed_vectors [$];
    int      mismatches = 0;
    int      items_sent = 0;
    bit      src_idle_on = 1'b1;
    bit      sink_idle_on = 1'b1;
    int      hold_req = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_coalescer();
        page_limit = pwvc_pkg::LIMIT_RESET;
        xf_open    = 1'b0;
        xf_owner   = '0;
        xf_first   = '0;
        xf_total   = '0;
        xf_used    = 0;
        xf_head    = 0;
        for (int i = 0; i < pwvc_pkg::VEC_DEPTH; i++) begin
            ring_base[i] = '0;
            ring_len[i]  = '0;
        end
    endfunction

    // queue the open transfer's vectors in logical order
    function automatic void close_transfer();
        sg_vec_t v;
        if (!xf_open) return;
        for (int i = 0; i < xf_used; i++) begin
            v.idx    = pwvc_pkg::VEC_AW'(i);
            v.base   = ring_base[(xf_head + i) % pwvc_pkg::VEC_DEPTH];
            v.frames = ring_len[(xf_head + i) % pwvc_pkg::VEC_DEPTH];
            v.owner  = xf_owner;
            v.first  = xf_first;
            v.total  = xf_total;
            v.last   = (i == xf_used - 1);
            closed_vectors.push_back(v);
        end
    endfunction

    function automatic bit merge_page(page_item_t it);
        logic [63:0] after;
        int unsigned limit;
        int          tail;
        int          slot_n;
        bit          before_ok;
        limit     = (page_limit == 0) ? 32'(pwvc_pkg::LIMIT_MAX) : 32'(page_limit);
        after     = 64'(xf_first) + 64'(xf_total);
        before_ok = (xf_first != 0) && (it.lpage == xf_first - 1'b1);
        if (it.owner != xf_owner || xf_total >= limit || xf_used == 0) return 1'b0;
        tail = (xf_head + xf_used - 1) % pwvc_pkg::VEC_DEPTH;
        if (64'(it.lpage) == after &&
            64'(it.frame) == 64'(ring_base[tail]) + 64'(ring_len[tail])) begin
            ring_len[tail]++;
            xf_total++;
            return 1'b1;
        end
        if (before_ok && ring_base[xf_head] != 0 &&
            it.frame == ring_base[xf_head] - 1'b1) begin
            ring_base[xf_head] = it.frame;
            ring_len[xf_head]++;
            xf_first = it.lpage;
            xf_total++;
            return 1'b1;
        end
        if ((64'(it.lpage) == after || before_ok) && xf_used < pwvc_pkg::VEC_DEPTH) begin
            if (it.lpage < xf_first) begin
                xf_head  = (xf_head + pwvc_pkg::VEC_DEPTH - 1) % pwvc_pkg::VEC_DEPTH;
                slot_n   = xf_head;
                xf_first = it.lpage;
            end else begin
                slot_n = (xf_head + xf_used) % pwvc_pkg::VEC_DEPTH;
            end
            ring_base[slot_n] = it.frame;
            ring_len[slot_n]  = 1;
            xf_used++;
            xf_total++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void coalesce_page(page_item_t it);
        if (it.flush) begin
            close_transfer();
            xf_open  = 1'b0;
            xf_used  = 0;
            xf_total = '0;
            return;
        end
        if (xf_open && merge_page(it)) return;
        close_transfer();
        xf_open      = 1'b1;
        xf_owner     = it.owner;
        xf_first     = it.lpage;
        xf_total     = 1;
        xf_head      = 0;
        xf_used      = 1;
        ring_base[0] = it.frame;
        ring_len[0]  = 1;
    endfunction

    function automatic logic [pwvc_pkg::FRAME_W-1:0] rand_frame();
        return {4'($urandom_range(0, 15)), 32'($urandom)};
    endfunction

    function automatic page_item_t mk_page(logic [pwvc_pkg::OWNER_W-1:0] o,
                                           logic [pwvc_pkg::FRAME_W-1:0] f,
                                           logic [pwvc_pkg::PAGE_W-1:0]  lp);
        page_item_t it;
        it.owner = o;
        it.frame = f;
        it.lpage = lp;
        it.flush = 1'b0;
        return it;
    endfunction

    // the page fields of a flush carry noise
    function automatic page_item_t mk_flush();
        page_item_t it;
        it       = mk_page(pwvc_pkg::OWNER_W'($urandom), rand_frame(),
                           pwvc_pkg::PAGE_W'($urandom));
        it.flush = 1'b1;
        return it;
    endfunction

    // build a page that relates to the open transfer in the given way
    function automatic page_item_t shaped_page(page_shape_t shape);
        page_item_t it;
        int         tail;
        it = mk_page(pwvc_pkg::OWNER_W'($urandom), rand_frame(), pwvc_pkg::PAGE_W'($urandom));
        case ($urandom_range(0, 7))
            0: it.frame = '0;
            1: it.frame = '1;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: it.lpage = pwvc_pkg::PAGE_W'($urandom_range(0, 3));
            1: it.lpage = '1 - pwvc_pkg::PAGE_W'($urandom_range(0, 3));
            default: ;
        endcase
        if (shape == PG_FRESH || !xf_open) return it;
        tail     = (xf_head + xf_used - 1) % pwvc_pkg::VEC_DEPTH;
        it.owner = xf_owner;
        it.frame = rand_frame();
        case (shape)
            PG_TAIL_EXT: begin
                it.lpage = xf_first + xf_total;
                it.frame = ring_base[tail] + ring_len[tail];
            end
            PG_FRONT_EXT: begin
                it.lpage = xf_first - 1'b1;
                it.frame = ring_base[xf_head] - 1'b1;
            end
            PG_NEW_TAIL:  it.lpage = xf_first + xf_total;
            PG_NEW_FRONT: it.lpage = xf_first - 1'b1;
            PG_OWNER_SWAP: begin
                it.owner = xf_owner ^ pwvc_pkg::OWNER_W'($urandom_range(1, 65535));
                it.lpage = xf_first + xf_total;
                it.frame = ring_base[tail] + ring_len[tail];
            end
            PG_GAP: it.lpage = xf_first + xf_total + 1 +
                               pwvc_pkg::PAGE_W'($urandom_range(0, 50));
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_item(page_item_t it);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, it.lpage, it.frame, it.owner};
        s_tuser  <= it.flush;
        do @(posedge aclk); while (!s_tready);
        coalesce_page(it);
        items_sent++;
    endtask

    // wait out all pending vectors plus the tail of a join still in work
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (closed_vectors.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_page_limit(logic [pwvc_pkg::CNT_W-1:0] value);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        page_limit = value;
        cfg_valid <= 1'b0;
    endtask

    // one transfer: an opening page, a run of pages shaped to join, then something that closes it
    task automatic send_stream(int joins, bit vectors_only);
        int k;
        send_item(shaped_page(PG_FRESH));
        for (int j = 0; j < joins; j++) begin
            k = $urandom_range(0, 9);
            if (vectors_only)
                send_item(shaped_page(k < 5 ? PG_NEW_TAIL : PG_NEW_FRONT));
            else if (k < 4)
                send_item(shaped_page(PG_TAIL_EXT));
            else if (k < 6)
                send_item(shaped_page(PG_FRONT_EXT));
            else if (k < 8)
                send_item(shaped_page(PG_NEW_TAIL));
            else
                send_item(shaped_page(PG_NEW_FRONT));
        end
        case ($urandom_range(0, 3))
            0: send_item(mk_flush());
            1: send_item(shaped_page(PG_OWNER_SWAP));
            2: send_item(shaped_page(PG_GAP));
            default: send_item(shaped_page(PG_FRESH));
        endcase
    endtask

    task automatic test_flush_and_open();
        logic [pwvc_pkg::OWNER_W-1:0] o;
        o = pwvc_pkg::OWNER_W'($urandom);
        send_item(mk_flush());
        send_item(mk_page(o, 36'd2000, 32'd500));
        send_item(shaped_page(PG_TAIL_EXT));
        send_item(shaped_page(PG_FRONT_EXT));
        send_item(shaped_page(PG_NEW_TAIL));
        send_item(shaped_page(PG_NEW_FRONT));
        send_item(shaped_page(PG_OWNER_SWAP));
        send_item(mk_flush());
    endtask

    // no wrap of logical pages or frames at either end of their range
    task automatic test_range_ends();
        logic [pwvc_pkg::OWNER_W-1:0] o;
        o = pwvc_pkg::OWNER_W'($urandom);
        send_item(mk_page(o, '1, 32'hFFFF_FFFE));
        send_item(mk_page(o, '0, 32'hFFFF_FFFF));
        send_item(mk_page(o, 36'd1, 32'h0));
        send_item(mk_page(o, '0, 32'hFFFF_FFFF));
        send_item(mk_page(o, '1, 32'hFFFF_FFFE));
        send_item(mk_flush());
    endtask

    task automatic test_page_limit();
        set_page_limit(16'd1);
        send_item(mk_page(pwvc_pkg::OWNER_W'($urandom), rand_frame(), 32'h1000_0000));
        send_item(shaped_page(PG_TAIL_EXT));
        set_page_limit(16'd3);
        repeat (3) send_item(shaped_page(PG_TAIL_EXT));
        set_page_limit(pwvc_pkg::LIMIT_RESET);
        repeat (3) send_item(shaped_page(PG_TAIL_EXT));
        // lowered below the open count: next page closes
        set_page_limit(16'd2);
        send_item(shaped_page(PG_TAIL_EXT));
        set_page_limit(16'd0);
        repeat (2) send_item(shaped_page(PG_TAIL_EXT));
        send_item(mk_flush());
    endtask

    task automatic test_vector_full();
        set_page_limit(pwvc_pkg::LIMIT_MAX);
        send_item(mk_page(pwvc_pkg::OWNER_W'($urandom), rand_frame(), 32'h8000_0000));
        // the 32nd new vector finds the list full
        repeat (32) send_item(shaped_page($urandom_range(0, 1) ? PG_NEW_TAIL : PG_NEW_FRONT));
        send_item(mk_flush());
    endtask

    task automatic test_random_streams();
        logic [pwvc_pkg::CNT_W-1:0] limits [4] = '{16'd0, 16'd7, 16'd1,
                                                   pwvc_pkg::LIMIT_RESET};
        for (int p = 0; p < 4; p++) begin
            int stop;
            set_page_limit(limits[p]);
            src_idle_on  = (p != 0);
            sink_idle_on = (p != 0);
            stop = items_sent + 30;
            while (items_sent < stop) begin
                if ($urandom_range(0, 9) == 0)
                    send_item($urandom_range(0, 1) ? mk_flush() : shaped_page(PG_FRESH));
                else
                    send_stream($urandom_range(0, 10), 1'b0);
            end
        end
    endtask

    task automatic test_output_stall();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        hold_req++;
        send_stream(12, 1'b1);
        send_stream(5, 1'b0);
        send_item(mk_flush());
    endtask

    // result sink: random stalls, plus a long hold on request
    int stall_left = 0;
    int hold_left  = 0;
    int hold_done  = 0;
    always @(posedge aclk) begin
        if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void cmp_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        end
    endfunction

    function automatic void check_vector();
        sg_vec_t want;
        if (closed_vectors.size() == 0) begin
            mismatches++;
            $display("%0t: vector transfer with none pending, tdata 0x%0h", $time, m_tdata);
            return;
        end
        want = closed_vectors.pop_front();
        cmp_field("vec_index",       want.idx,    m_tdata[4:0]);
        cmp_field("vec_base_frame",  want.base,   m_tdata[40:5]);
        cmp_field("vec_frames",      want.frames, m_tdata[56:41]);
        cmp_field("xfer_owner",      want.owner,  m_tdata[72:57]);
        cmp_field("xfer_first_page", want.first,  m_tdata[104:73]);
        cmp_field("xfer_page_total", want.total,  m_tdata[120:105]);
        cmp_field("last_vec",        want.last,   m_tlast);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_vector();
    end

    initial begin
        clear_coalescer();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_flush_and_open();
        test_range_ends();
        test_page_limit();
        test_vector_full();
        test_random_streams();
        test_output_stall();
        drain_block();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: FAIL");
        $finish;
    end

endmodule
